### src/fppc_pkg.sv
// shared types and constants for the flow pair packet counter
`default_nettype none

package fppc_pkg;

  localparam int AddrW  = 32;
  localparam int CountW = 32;
  localparam int IdxW   = 6;
  localparam int LevelW = 7;

  // command codes of an input word
  typedef enum logic {
    CMD_COUNT = 1'b0,
    CMD_READ  = 1'b1
  } cmd_e;

  // input word
  typedef struct packed {
    cmd_e              cmd;
    logic [AddrW-1:0]  src_addr;
    logic [AddrW-1:0]  dst_addr;
    logic [IdxW-1:0]   entry_index;
  } in_word_t;

  // result word
  typedef struct packed {
    logic              hit;
    logic              inserted;
    logic              overflow;
    logic              entry_valid;
    logic [AddrW-1:0]  entry_src;
    logic [AddrW-1:0]  entry_dst;
    logic [CountW-1:0] entry_count;
    logic [LevelW-1:0] fill_level;
  } out_word_t;

  // request token walking down the cell chain
  typedef struct packed {
    logic              busy;
    cmd_e              cmd;
    logic [AddrW-1:0]  src_addr;
    logic [AddrW-1:0]  dst_addr;
    logic [IdxW-1:0]   entry_index;
    logic              hit;
    logic              inserted;
    logic              entry_valid;
    logic [AddrW-1:0]  entry_src;
    logic [AddrW-1:0]  entry_dst;
    logic [CountW-1:0] entry_count;
  } tok_t;

endpackage

`default_nettype wire

### src/fppc_cell.sv
// one table entry cell: holds an address pair and its count, passes the token on
`default_nettype none

module fppc_cell #(
  parameter int INDEX = 0
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire fppc_pkg::tok_t tok_i,
  output fppc_pkg::tok_t      tok_o
);

  logic                          vld_q;
  logic [fppc_pkg::AddrW-1:0]    src_q;
  logic [fppc_pkg::AddrW-1:0]    dst_q;
  logic [fppc_pkg::CountW-1:0]   cnt_q;
  logic                          busy_q;
  fppc_pkg::tok_t                tok_d;
  fppc_pkg::tok_t                tok_q;
  logic                          match;
  logic                          claim;
  logic                          read_sel;

  // compare, claim and read select
  always_comb begin
    match    = vld_q && (src_q == tok_i.src_addr) && (dst_q == tok_i.dst_addr);
    claim    = tok_i.busy && (tok_i.cmd == fppc_pkg::CMD_COUNT) &&
               !tok_i.hit && !tok_i.inserted;
    read_sel = tok_i.busy && (tok_i.cmd == fppc_pkg::CMD_READ) && vld_q &&
               (INDEX < (2 ** fppc_pkg::IdxW)) &&
               (tok_i.entry_index == fppc_pkg::IdxW'(INDEX));
    tok_d = tok_i;
    if (claim && match) begin
      tok_d.hit = 1'b1;
    end else if (claim && !vld_q) begin
      tok_d.inserted = 1'b1;
    end
    if (read_sel) begin
      tok_d.entry_valid = 1'b1;
      tok_d.entry_src   = src_q;
      tok_d.entry_dst   = dst_q;
      tok_d.entry_count = cnt_q;
    end
  end

  // entry valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (claim && !vld_q) begin
      vld_q <= 1'b1;
    end
  end

  // entry payload: append or saturating increment
  always_ff @(posedge clk_i) begin
    if (claim && match) begin
      if (cnt_q != '1) begin
        cnt_q <= cnt_q + fppc_pkg::CountW'(1);
      end
    end else if (claim && !vld_q) begin
      src_q <= tok_i.src_addr;
      dst_q <= tok_i.dst_addr;
      cnt_q <= fppc_pkg::CountW'(1);
    end
  end

  // token stage to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= tok_i.busy;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  always_comb begin
    tok_o      = tok_q;
    tok_o.busy = busy_q;
  end

endmodule

`default_nettype wire

### src/flow_pair_packet_counter.sv
// flow pair packet counter: chain of entry cells with input control and result register
//
//   channel   direction  handshake                 payload
//   in        input      in_valid_i / in_stall_o   in_word_i  (fppc_pkg::in_word_t)
//   out       output     out_valid_o / out_stall_i out_word_o (fppc_pkg::out_word_t)
//
// each word walks the row of TABLE_ENTRIES cells, one cell per cycle, and its
// result is then written to the output register.
// one word is in the chain at a time; the next is taken once the result leaves
// the output register (or in the cycle it leaves).
// reset clears all entry valid bits and the fill level; no clearing pass is needed.
// a stall on the output holds the result register and keeps the input stalled.
`default_nettype none

module flow_pair_packet_counter #(
  parameter int TABLE_ENTRIES = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire fppc_pkg::in_word_t  in_word_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output fppc_pkg::out_word_t      out_word_o
);

  localparam int FillW = $clog2(TABLE_ENTRIES + 1);

  fppc_pkg::tok_t          tok [TABLE_ENTRIES+1];
  fppc_pkg::tok_t          tok_end;
  logic                    busy_q;
  logic                    out_valid_q;
  fppc_pkg::out_word_t     out_q;
  logic [FillW-1:0]        fill_q;
  logic [FillW-1:0]        fill_d;
  logic                    in_take;

  // input handshake and token injection
  assign in_stall_o = busy_q || (out_valid_q && out_stall_i);
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    tok[0]             = '0;
    tok[0].busy        = in_take;
    tok[0].cmd         = in_word_i.cmd;
    tok[0].src_addr    = in_word_i.src_addr;
    tok[0].dst_addr    = in_word_i.dst_addr;
    tok[0].entry_index = in_word_i.entry_index;
  end

  // row of entry cells
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    fppc_cell #(
      .INDEX (i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (tok[i]),
      .tok_o  (tok[i+1])
    );
  end

  assign tok_end = tok[TABLE_ENTRIES];

  // fill level after the word leaving the chain
  always_comb begin
    fill_d = fill_q;
    if (tok_end.busy && tok_end.inserted) begin
      fill_d = fill_q + FillW'(1);
    end
  end

  // control: busy, output valid, fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      fill_q      <= '0;
    end else begin
      if (in_take) begin
        busy_q <= 1'b1;
      end else if (tok_end.busy) begin
        busy_q <= 1'b0;
      end
      if (tok_end.busy) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      fill_q <= fill_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (tok_end.busy) begin
      out_q.hit         <= tok_end.hit;
      out_q.inserted    <= tok_end.inserted;
      out_q.overflow    <= (tok_end.cmd == fppc_pkg::CMD_COUNT) &&
                           !tok_end.hit && !tok_end.inserted;
      out_q.entry_valid <= tok_end.entry_valid;
      out_q.entry_src   <= tok_end.entry_src;
      out_q.entry_dst   <= tok_end.entry_dst;
      out_q.entry_count <= tok_end.entry_count;
      out_q.fill_level  <= fppc_pkg::LevelW'(fill_d);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire

### tb/sv/flow_pair_packet_counter_tb.sv
// self-checking testbench for the flow pair packet counter
module flow_pair_packet_counter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_ENTRIES  = 64;
  localparam int RANDOM_WORDS   = 1880;
  localparam int IDLE_PERCENT   = 11;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_PRINTS     = 20;
  localparam int KNOWN_PAIRS    = 80;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  fppc_pkg::in_word_t  in_word   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  fppc_pkg::out_word_t out_word;

  flow_pair_packet_counter #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word)
  );

  // words waiting to be sent, and replies the table must give, oldest first
  fppc_pkg::in_word_t  request_words[$];
  fppc_pkg::out_word_t table_replies[$];

  // own copy of the flow table
  logic [fppc_pkg::AddrW-1:0]  flow_src[TABLE_ENTRIES];
  logic [fppc_pkg::AddrW-1:0]  flow_dst[TABLE_ENTRIES];
  logic [fppc_pkg::CountW-1:0] flow_cnt[TABLE_ENTRIES];
  int                          flows_used = 0;

  int  words_in      = 0;
  int  words_out     = 0;
  int  mismatches    = 0;
  int  n_hits        = 0;
  int  n_inserts     = 0;
  int  n_drops       = 0;
  int  n_reads_full  = 0;
  int  n_reads_empty = 0;
  int  idle_cycles   = 0;
  int  words_seen    = 0;
  bit  quiet;

  // long stretch with neither side idling
  assign quiet = (words_in >= 700) && (words_in < 1000);

  // clock, 20 ns period
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // apply one word to the flow table copy and return the reply it causes
  function automatic fppc_pkg::out_word_t flow_table_update(fppc_pkg::in_word_t w);
    fppc_pkg::out_word_t r;
    int                  i;
    bit                  found;
    r     = '0;
    found = 1'b0;
    if (w.cmd == fppc_pkg::CMD_COUNT) begin
      for (i = 0; i < flows_used; i++) begin
        if (!found && flow_src[i] == w.src_addr && flow_dst[i] == w.dst_addr) begin
          found = 1'b1;
          if (flow_cnt[i] != '1) flow_cnt[i] = flow_cnt[i] + fppc_pkg::CountW'(1);
        end
      end
      if (found) begin
        r.hit = 1'b1;
      end else if (flows_used < TABLE_ENTRIES) begin
        flow_src[flows_used] = w.src_addr;
        flow_dst[flows_used] = w.dst_addr;
        flow_cnt[flows_used] = fppc_pkg::CountW'(1);
        flows_used++;
        r.inserted = 1'b1;
      end else begin
        r.overflow = 1'b1;
      end
    end else if (int'(w.entry_index) < flows_used) begin
      r.entry_valid = 1'b1;
      r.entry_src   = flow_src[w.entry_index];
      r.entry_dst   = flow_dst[w.entry_index];
      r.entry_count = flow_cnt[w.entry_index];
    end
    r.fill_level = fppc_pkg::LevelW'(flows_used);
    return r;
  endfunction

  function automatic fppc_pkg::in_word_t make_word(fppc_pkg::cmd_e c,
                                                   logic [fppc_pkg::AddrW-1:0] s,
                                                   logic [fppc_pkg::AddrW-1:0] d,
                                                   logic [fppc_pkg::IdxW-1:0] ix);
    fppc_pkg::in_word_t w;
    w.cmd         = c;
    w.src_addr    = s;
    w.dst_addr    = d;
    w.entry_index = ix;
    return w;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < MAX_PRINTS) $display("mismatch at result %0d: %s", words_out, msg);
    mismatches++;
  endtask

  // input side: take accepted words, predict their replies
  always @(posedge clk) begin
    fppc_pkg::out_word_t r;
    if (rst_n && in_valid && !in_stall) begin
      r = flow_table_update(request_words[0]);
      void'(request_words.pop_front());
      table_replies.push_back(r);
      words_in++;
      if (in_word.cmd == fppc_pkg::CMD_COUNT) begin
        n_hits    += r.hit;
        n_inserts += r.inserted;
        n_drops   += r.overflow;
      end else if (r.entry_valid) begin
        n_reads_full++;
      end else begin
        n_reads_empty++;
      end
    end
  end

  // input driver: hold a stalled word, otherwise offer the next or idle
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && words_in == words_seen) begin
      in_valid <= 1'b1;
    end else if (request_words.size() > 0 &&
                 (quiet || $urandom_range(99) >= IDLE_PERCENT)) begin
      in_valid <= 1'b1;
      in_word  <= request_words[0];
    end else begin
      in_valid <= 1'b0;
    end
    words_seen = words_in;
  end

  // output side stalls at random
  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= !quiet && ($urandom_range(99) < IDLE_PERCENT);
  end

  // monitor: compare each accepted reply with the oldest prediction
  always @(posedge clk) begin
    fppc_pkg::out_word_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (table_replies.size() == 0) begin
        report_mismatch($sformatf("reply %h with none pending", out_word));
      end else begin
        e = table_replies.pop_front();
        if (out_word.hit !== e.hit)
          report_mismatch($sformatf("hit %b, want %b", out_word.hit, e.hit));
        if (out_word.inserted !== e.inserted)
          report_mismatch($sformatf("inserted %b, want %b", out_word.inserted, e.inserted));
        if (out_word.overflow !== e.overflow)
          report_mismatch($sformatf("overflow %b, want %b", out_word.overflow, e.overflow));
        if (out_word.entry_valid !== e.entry_valid)
          report_mismatch($sformatf("entry_valid %b, want %b",
                                    out_word.entry_valid, e.entry_valid));
        if (out_word.entry_src !== e.entry_src)
          report_mismatch($sformatf("entry_src %h, want %h", out_word.entry_src, e.entry_src));
        if (out_word.entry_dst !== e.entry_dst)
          report_mismatch($sformatf("entry_dst %h, want %h", out_word.entry_dst, e.entry_dst));
        if (out_word.entry_count !== e.entry_count)
          report_mismatch($sformatf("entry_count %h, want %h",
                                    out_word.entry_count, e.entry_count));
        if (out_word.fill_level !== e.fill_level)
          report_mismatch($sformatf("fill_level %0d, want %0d",
                                    out_word.fill_level, e.fill_level));
      end
      words_out++;
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", idle_cycles);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // stimulus and end of run
  initial begin
    logic [fppc_pkg::AddrW-1:0] known_src[$];
    logic [fppc_pkg::AddrW-1:0] known_dst[$];
    logic [fppc_pkg::AddrW-1:0] s;
    logic [fppc_pkg::AddrW-1:0] d;
    logic [fppc_pkg::AddrW-1:0] flip;
    int                         roll;
    int                         k;
    int                         n;

    // directed: empty table reads, address extremes, near matches, reads past fill
    request_words.push_back(make_word(fppc_pkg::CMD_READ, '1, '1, 6'd0));
    request_words.push_back(make_word(fppc_pkg::CMD_READ, '0, '0, 6'd63));
    request_words.push_back(make_word(fppc_pkg::CMD_COUNT, '0, '0, 6'd63));
    request_words.push_back(make_word(fppc_pkg::CMD_COUNT, '1, '1, 6'd0));
    request_words.push_back(make_word(fppc_pkg::CMD_COUNT, '0, '0, 6'd0));
    request_words.push_back(make_word(fppc_pkg::CMD_COUNT, '0, '1, 6'd63));
    request_words.push_back(make_word(fppc_pkg::CMD_COUNT, '1, '0, 6'd21));
    request_words.push_back(make_word(fppc_pkg::CMD_COUNT, 32'hAAAA_AAAA, 32'h5555_5555,
                                      6'd42));
    request_words.push_back(make_word(fppc_pkg::CMD_COUNT, 32'h5555_5555, 32'hAAAA_AAAA,
                                      6'd0));
    request_words.push_back(make_word(fppc_pkg::CMD_COUNT, 32'hAAAA_AAAA, 32'h5555_5555,
                                      6'd63));
    request_words.push_back(make_word(fppc_pkg::CMD_COUNT, '1, '1, 6'd0));
    request_words.push_back(make_word(fppc_pkg::CMD_COUNT, '0, '0, 6'd0));
    request_words.push_back(make_word(fppc_pkg::CMD_READ, 32'hAAAA_AAAA, 32'h5555_5555,
                                      6'd0));
    request_words.push_back(make_word(fppc_pkg::CMD_READ, 32'h5555_5555, 32'hAAAA_AAAA,
                                      6'd1));
    request_words.push_back(make_word(fppc_pkg::CMD_READ, '0, '0, 6'd2));
    request_words.push_back(make_word(fppc_pkg::CMD_READ, '1, '1, 6'd5));
    request_words.push_back(make_word(fppc_pkg::CMD_READ, '0, '1, 6'd6));
    request_words.push_back(make_word(fppc_pkg::CMD_READ, '1, '0, 6'd7));
    request_words.push_back(make_word(fppc_pkg::CMD_READ, '0, '0, 6'd63));
    request_words.push_back(make_word(fppc_pkg::CMD_READ, '0, '0, 6'd42));

    // random: repeats of known pairs, near misses, new pairs and reads;
    // the table fills early, after that new pairs are dropped.
    // count saturation needs 2^32 - 1 counted words on one pair and is out of reach here
    for (n = 0; n < RANDOM_WORDS; n++) begin
      roll = $urandom_range(99);
      if (roll < 25) begin
        request_words.push_back(make_word(fppc_pkg::CMD_READ, $urandom, $urandom,
                                          fppc_pkg::IdxW'($urandom_range(63))));
      end else begin
        if (roll < 65 && known_src.size() > 0) begin
          k = $urandom_range(known_src.size() - 1);
          s = known_src[k];
          d = known_dst[k];
        end else if (roll < 75 && known_src.size() > 0) begin
          k    = $urandom_range(known_src.size() - 1);
          flip = fppc_pkg::AddrW'(1) << $urandom_range(fppc_pkg::AddrW - 1);
          s    = known_src[k];
          d    = known_dst[k];
          if ($urandom_range(1)) s = s ^ flip;
          else d = d ^ flip;
          if (known_src.size() < KNOWN_PAIRS) begin
            known_src.push_back(s);
            known_dst.push_back(d);
          end
        end else begin
          s = $urandom;
          d = $urandom;
          if (known_src.size() < KNOWN_PAIRS) begin
            known_src.push_back(s);
            known_dst.push_back(d);
          end
        end
        request_words.push_back(make_word(fppc_pkg::CMD_COUNT, s, d,
                                          fppc_pkg::IdxW'($urandom)));
      end
    end

    // apply reset, then release it at a falling clock edge
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // drain, then let the cell chain settle
    while (request_words.size() != 0 || table_replies.size() != 0) @(posedge clk);
    repeat (2 * TABLE_ENTRIES + 8) @(posedge clk);

    $display("run: %0d words, %0d hits, %0d new flows, %0d drops on a full table",
             words_in, n_hits, n_inserts, n_drops);
    $display("reads: %0d of filled entries, %0d past the fill level, final level %0d",
             n_reads_full, n_reads_empty, flows_used);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
